// ===== sv/chm2k_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// chm2k_pkg: shared types and constants of the two-key chained hash map
// Sizes of the bucket table and node pool, operation and status codes, the
// node record layout and the request/response bundles of the node store.
// ----------------------------------------------------------------------------
package chm2k_pkg;

  // Table geometry; the bucket count is a power of two so the hash is a mask
  localparam int NUM_BUCKETS = 64;
  localparam int POOL_NODES  = 128;

  localparam int BKT_W  = $clog2(NUM_BUCKETS);
  localparam int NODE_W = $clog2(POOL_NODES);
  localparam int CNT_W  = $clog2(POOL_NODES + 1);

  // Field widths
  localparam int OP_W  = 2;
  localparam int ROW_W = 16;
  localparam int COL_W = 16;
  localparam int VAL_W = 32;
  localparam int ST_W  = 2;

  typedef enum logic [OP_W-1:0] {
    OP_INSERT = 2'd0,
    OP_QUERY  = 2'd1,
    OP_CLEAR  = 2'd2
  } op_e;

  typedef enum logic [ST_W-1:0] {
    ST_OK      = 2'd0,
    ST_PRESENT = 2'd1,
    ST_FULL    = 2'd2,
    ST_MISSING = 2'd3
  } status_e;

  // Key and value of one pool node
  typedef struct packed {
    logic [ROW_W-1:0] row;
    logic [COL_W-1:0] col;
    logic [VAL_W-1:0] val;
  } node_t;

  // Forward link of one pool node
  typedef struct packed {
    logic              vld;
    logic [NODE_W-1:0] idx;
  } link_t;

  // Requests from the sequencer to the store
  typedef struct packed {
    logic [BKT_W-1:0]  bkt_raddr;
    logic              bval_clr;
    logic              head_we;
    logic [BKT_W-1:0]  head_waddr;
    logic [NODE_W-1:0] head_wdata;
    logic [NODE_W-1:0] node_raddr;
    logic              node_we;
    logic [NODE_W-1:0] node_waddr;
    node_t             node_wdata;
    logic              link_we;
    logic [NODE_W-1:0] link_waddr;
    link_t             link_wdata;
  } store_req_t;

  // Answers from the store
  typedef struct packed {
    logic              head_vld;
    logic [NODE_W-1:0] head_idx;
    node_t             node;
    link_t             link;
  } store_rsp_t;

  // Bucket of a key: XOR fold masked to the bucket count
  function automatic logic [BKT_W-1:0] bucket_of(logic [ROW_W-1:0] row,
                                                 logic [COL_W-1:0] col);
    logic [ROW_W-1:0] fold;
    fold = row ^ col;
    return fold[BKT_W-1:0];
  endfunction

endpackage

// ===== sv/chained_hash_map_two_key_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// chained_hash_map_two_key_top: two-key hash map with chained buckets
// Sequencer that walks bucket chains through one shared key comparator.
// ----------------------------------------------------------------------------
// Takes one operation at a time and answers each with exactly one result.
// The key (row, column) hashes to a bucket by XOR fold; the sequencer reads
// the bucket head, then walks the chain one node per cycle through the node
// RAM read port, comparing keys in a single shared comparator. A query hit
// answers from the compare of the matching node; a query miss, also in an
// empty bucket, passes the miss step. An insert of a new key passes the miss
// step, writes the new node and, behind a non-empty chain, links the old
// tail to it. A present key answers like a hit, a full pool like a miss.
// Clear and the unused op code go straight to the final step. The block is
// not ready while an operation is in progress and is ready again in the
// same cycle that the result appears. A result waiting in the output
// register holds the next one back only at its last step. No clearing pass
// after reset.
// ----------------------------------------------------------------------------
module chained_hash_map_two_key_top
  import chm2k_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  logic [OP_W-1:0]  op_i,
  input  logic [ROW_W-1:0] row_key_i,
  input  logic [COL_W-1:0] col_key_i,
  input  logic [VAL_W-1:0] item_value_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output logic [ST_W-1:0]  status_o,
  output logic [VAL_W-1:0] found_value_o
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_FIRST,
    S_CMP,
    S_MISS,
    S_WR_NODE,
    S_WR_LINK,
    S_FIN
  } state_e;

  state_e            state_q, state_d;
  logic [CNT_W-1:0]  nodes_used_q, nodes_used_d;
  logic              out_valid_q, out_valid_d;
  logic [ST_W-1:0]   out_status_q, out_status_d;
  logic [VAL_W-1:0]  out_value_q, out_value_d;

  logic [OP_W-1:0]   op_q;
  logic [ROW_W-1:0]  row_q;
  logic [COL_W-1:0]  col_q;
  logic [VAL_W-1:0]  val_q;
  logic [BKT_W-1:0]  bkt_q;
  logic [NODE_W-1:0] cur_q, cur_d;
  logic [NODE_W-1:0] tail_q, tail_d;
  logic              has_tail_q, has_tail_d;
  logic [ST_W-1:0]   res_status_q, res_status_d;
  logic [VAL_W-1:0]  res_value_q, res_value_d;

  logic              in_xfer;
  logic [BKT_W-1:0]  in_bkt;
  logic              key_hit;
  logic              pool_full;
  logic [NODE_W-1:0] new_idx;
  store_req_t        req;
  store_rsp_t        rsp;

  assign in_ready_o = (state_q == S_IDLE);
  assign in_xfer    = in_valid_i && in_ready_o;
  assign in_bkt     = bucket_of(row_key_i, col_key_i);
  assign pool_full  = (nodes_used_q >= CNT_W'(POOL_NODES));
  assign new_idx    = nodes_used_q[NODE_W-1:0];

  // Shared key comparator
  assign key_hit = (rsp.node.row == row_q) && (rsp.node.col == col_q);

  chm2k_store u_store (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req),
    .rsp_o  (rsp)
  );

  // Sequencer next state and store requests
  always_comb begin
    state_d      = state_q;
    nodes_used_d = nodes_used_q;
    out_valid_d  = out_valid_q;
    out_status_d = out_status_q;
    out_value_d  = out_value_q;
    cur_d        = cur_q;
    tail_d       = tail_q;
    has_tail_d   = has_tail_q;
    res_status_d = res_status_q;
    res_value_d  = res_value_q;

    req            = '0;
    req.bkt_raddr  = bkt_q;
    req.node_raddr = cur_q;

    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      S_IDLE: begin
        // Look up the bucket of the offered key straight away
        req.bkt_raddr = in_bkt;
        if (in_xfer) begin
          has_tail_d   = 1'b0;
          res_status_d = ST_OK;
          res_value_d  = '0;
          case (op_i)
            OP_INSERT, OP_QUERY: begin
              state_d = rsp.head_vld ? S_FIRST : S_MISS;
            end
            OP_CLEAR: begin
              req.bval_clr = 1'b1;
              nodes_used_d = '0;
              state_d      = S_FIN;
            end
            default: begin
              state_d = S_FIN;
            end
          endcase
        end
      end

      S_FIRST: begin
        // Head index arrives; fetch the first node
        req.node_raddr = rsp.head_idx;
        cur_d          = rsp.head_idx;
        state_d        = S_CMP;
      end

      S_CMP: begin
        if (key_hit) begin
          if (op_q == OP_INSERT) begin
            res_status_d = ST_PRESENT;
          end else begin
            res_value_d = rsp.node.val;
          end
          state_d = S_FIN;
        end else begin
          // Advance along the chain, remembering the last node seen
          tail_d     = cur_q;
          has_tail_d = 1'b1;
          if (rsp.link.vld) begin
            req.node_raddr = rsp.link.idx;
            cur_d          = rsp.link.idx;
          end else begin
            state_d = S_MISS;
          end
        end
      end

      S_MISS: begin
        if (op_q == OP_QUERY) begin
          res_status_d = ST_MISSING;
          state_d      = S_FIN;
        end else if (pool_full) begin
          res_status_d = ST_FULL;
          state_d      = S_FIN;
        end else begin
          state_d = S_WR_NODE;
        end
      end

      S_WR_NODE: begin
        // Write the new node with an open link
        req.node_we         = 1'b1;
        req.node_waddr      = new_idx;
        req.node_wdata.row  = row_q;
        req.node_wdata.col  = col_q;
        req.node_wdata.val  = val_q;
        req.link_we         = 1'b1;
        req.link_waddr      = new_idx;
        req.link_wdata.vld  = 1'b0;
        req.link_wdata.idx  = '0;
        if (has_tail_q) begin
          state_d = S_WR_LINK;
        end else begin
          req.head_we    = 1'b1;
          req.head_waddr = bkt_q;
          req.head_wdata = new_idx;
          nodes_used_d   = nodes_used_q + 1'b1;
          state_d        = S_FIN;
        end
      end

      S_WR_LINK: begin
        // Hook the new node onto the old tail
        req.link_we        = 1'b1;
        req.link_waddr     = tail_q;
        req.link_wdata.vld = 1'b1;
        req.link_wdata.idx = new_idx;
        nodes_used_d       = nodes_used_q + 1'b1;
        state_d            = S_FIN;
      end

      S_FIN: begin
        // Hand the result over once the output register is free
        if (!out_valid_q || out_ready_i) begin
          out_valid_d  = 1'b1;
          out_status_d = res_status_q;
          out_value_d  = res_value_q;
          state_d      = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // State, pool count and output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      nodes_used_q <= '0;
      out_valid_q  <= 1'b0;
      out_status_q <= '0;
      out_value_q  <= '0;
    end else begin
      state_q      <= state_d;
      nodes_used_q <= nodes_used_d;
      out_valid_q  <= out_valid_d;
      out_status_q <= out_status_d;
      out_value_q  <= out_value_d;
    end
  end

  // Item and walk registers
  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      op_q  <= op_i;
      row_q <= row_key_i;
      col_q <= col_key_i;
      val_q <= item_value_i;
      bkt_q <= in_bkt;
    end
    cur_q        <= cur_d;
    tail_q       <= tail_d;
    has_tail_q   <= has_tail_d;
    res_status_q <= res_status_d;
    res_value_q  <= res_value_d;
  end

  assign out_valid_o   = out_valid_q;
  assign status_o      = out_status_q;
  assign found_value_o = out_value_q;

  // The pool count never runs past the pool
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    nodes_used_q <= CNT_W'(POOL_NODES))
    else $error("node pool count overflow");

  // A node is written only while the pool has room
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_WR_NODE) |-> !pool_full)
    else $error("node written into a full pool");

  // A transfer always leaves the block busy in the next cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_xfer |=> !in_ready_o)
    else $error("ready right after a transfer");

  // A new result appears only out of the final step
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !$past(out_valid_q)) |-> ($past(state_q) == S_FIN))
    else $error("result produced outside the final step");

endmodule

// ===== sv/chm2k_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// chm2k_ram: generic simple dual-port RAM
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module chm2k_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write and registered read
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== sv/chm2k_store.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// chm2k_store: bucket table and node pool of the hash map
// Bucket heads and node records live in RAMs; bucket valid bits are flops so
// that reset and clear empty the whole table at once.
// ----------------------------------------------------------------------------
module chm2k_store
  import chm2k_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  store_req_t req_i,
  output store_rsp_t rsp_o
);

  logic [NUM_BUCKETS-1:0]       bval_q;
  logic [NODE_W-1:0]            head_rdata;
  logic [$bits(node_t)-1:0]     node_rdata;
  logic [$bits(link_t)-1:0]     link_rdata;

  // Clear all buckets at once, mark a bucket occupied on its first head write
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bval_q <= '0;
    end else if (req_i.bval_clr) begin
      bval_q <= '0;
    end else if (req_i.head_we) begin
      bval_q[req_i.head_waddr] <= 1'b1;
    end
  end

  chm2k_ram #(
    .WIDTH (NODE_W),
    .DEPTH (NUM_BUCKETS)
  ) u_head_ram (
    .clk_i   (clk_i),
    .we_i    (req_i.head_we),
    .waddr_i (req_i.head_waddr),
    .wdata_i (req_i.head_wdata),
    .raddr_i (req_i.bkt_raddr),
    .rdata_o (head_rdata)
  );

  chm2k_ram #(
    .WIDTH ($bits(node_t)),
    .DEPTH (POOL_NODES)
  ) u_node_ram (
    .clk_i   (clk_i),
    .we_i    (req_i.node_we),
    .waddr_i (req_i.node_waddr),
    .wdata_i (req_i.node_wdata),
    .raddr_i (req_i.node_raddr),
    .rdata_o (node_rdata)
  );

  chm2k_ram #(
    .WIDTH ($bits(link_t)),
    .DEPTH (POOL_NODES)
  ) u_link_ram (
    .clk_i   (clk_i),
    .we_i    (req_i.link_we),
    .waddr_i (req_i.link_waddr),
    .wdata_i (req_i.link_wdata),
    .raddr_i (req_i.node_raddr),
    .rdata_o (link_rdata)
  );

  // Bucket valid is looked up combinationally at the read address
  assign rsp_o.head_vld = bval_q[req_i.bkt_raddr];
  assign rsp_o.head_idx = head_rdata;
  assign rsp_o.node     = node_t'(node_rdata);
  assign rsp_o.link     = link_t'(link_rdata);

endmodule
